### hw/rtl/rtu_frame_receiver_resync_defines.svh
// Assertion macros shared by the frame receiver RTL.
// Depends on i_clk and i_rst_n being in scope where the macros are used.
`ifndef RTU_FRAME_RECEIVER_RESYNC_DEFINES_SVH
`define RTU_FRAME_RECEIVER_RESYNC_DEFINES_SVH

// Implication checked only while out of reset.
`define RTU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on every edge, reset included.
`define RTU_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/rtu_frr_pkg.sv
// Shared types, constants and functions of the frame receiver.
// Used by every module of the block but rtu_ram; depends on nothing.
package rtu_frr_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int LEN_W = 9;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_CRC_ERR = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    localparam logic [7:0] FC_READ_HOLD = 8'h03;
    localparam logic [7:0] FC_WRITE_COIL = 8'h05;
    localparam logic [7:0] FC_WRITE_REG = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

    localparam logic [LEN_W-1:0] FIXED_LEN = LEN_W'(6);
    localparam logic [LEN_W-1:0] MULTI_HDR = LEN_W'(7);
    localparam int MULTI_CNT_POS = 6;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_fe_item;

    function automatic logic code_ok(input logic [7:0] c);
        return (c == FC_READ_HOLD) || (c == FC_WRITE_COIL) ||
               (c == FC_WRITE_REG) || (c == FC_WRITE_MULTI);
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### hw/rtl/rtu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/rtu_fe.sv
// Front end: accepts received bytes into a short queue for the back end.
// Depends on rtu_frr_pkg.
module rtu_fe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_rx_stall,
    output rtu_frr_pkg::t_fe_item o_item,
    input  logic                  i_pop
);
    localparam int QP_W = $clog2(rtu_frr_pkg::QUEUE_DEPTH);
    localparam int QC_W = $clog2(rtu_frr_pkg::QUEUE_DEPTH + 1);

    logic [7:0]      r_q [rtu_frr_pkg::QUEUE_DEPTH];
    logic [QP_W-1:0] r_wp;
    logic [QP_W-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_rx_stall = (r_cnt == QC_W'(rtu_frr_pkg::QUEUE_DEPTH));
    assign w_push = i_rx_valid && !o_rx_stall;
    assign w_pop = i_pop && (r_cnt != '0);
    assign o_item.valid = (r_cnt != '0);
    assign o_item.rx_byte = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_rx_byte;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

### hw/rtl/rtu_be.sv
// Back end: frame buffer, resync, length and CRC check, result output register.
// Depends on rtu_frr_pkg and rtu_ram.
module rtu_be (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_station_address,
    input  rtu_frr_pkg::t_fe_item i_item,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_frame_byte,
    output logic [5:0]            o_byte_index,
    output logic                  o_last_of_frame
);
    localparam int PW = rtu_frr_pkg::PTR_W;
    localparam int CW = rtu_frr_pkg::CNT_W;
    localparam int LW = rtu_frr_pkg::LEN_W;

    typedef enum logic [4:0] {
        S_IDLE, S_OVF, S_RS0, S_RS1, S_RS2, S_LEN0, S_LEN1, S_LEN2, S_LENCMP,
        S_CRC_RD, S_CRC_UP, S_CHK0, S_CHK1, S_CHK2, S_ERR, S_EMIT_RD, S_EMIT
    } t_state;

    t_state          r_state;
    logic [PW-1:0]   r_head;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [LW-1:0]   r_len;
    logic [15:0]     r_crc;
    logic [7:0]      r_b0;
    logic            r_ok;
    logic            r_out_valid;
    logic [1:0]      r_kind;
    logic [7:0]      r_frame_byte;
    logic [5:0]      r_byte_index;
    logic            r_last;

    logic            w_we;
    logic [PW-1:0]   w_waddr;
    logic            w_re;
    logic [PW-1:0]   w_raddr;
    logic [7:0]      w_rdata;
    logic            w_slot;
    logic [CW-1:0]   w_count_inc;

    rtu_ram #(.WIDTH(8), .DEPTH(rtu_frr_pkg::BUFFER_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_item.rx_byte),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_slot = !r_out_valid || !i_out_stall;
    assign w_count_inc = r_count + 1'b1;
    assign w_waddr = r_head + r_count[PW-1:0];

    always_comb begin
        o_pop = 1'b0;
        w_we = 1'b0;
        w_re = 1'b0;
        w_raddr = r_head;
        case (r_state)
            S_IDLE: begin
                o_pop = i_item.valid;
                w_we = i_item.valid && (r_count != CW'(rtu_frr_pkg::BUFFER_DEPTH));
            end
            S_RS0: w_re = 1'b1;
            S_RS1: begin
                w_re = 1'b1;
                w_raddr = r_head + PW'(1);
            end
            S_LEN0: begin
                w_re = 1'b1;
                w_raddr = r_head + PW'(1);
            end
            S_LEN1: begin
                w_re = 1'b1;
                w_raddr = r_head + PW'(rtu_frr_pkg::MULTI_CNT_POS);
            end
            S_CRC_RD, S_EMIT_RD: begin
                w_re = 1'b1;
                w_raddr = r_head + r_idx[PW-1:0];
            end
            S_CHK0: begin
                w_re = 1'b1;
                w_raddr = r_head + r_len[PW-1:0];
            end
            S_CHK1: begin
                w_re = 1'b1;
                w_raddr = r_head + r_len[PW-1:0] + PW'(1);
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        if (r_count == CW'(rtu_frr_pkg::BUFFER_DEPTH)) begin
                            r_state <= S_OVF;
                        end else begin
                            r_count <= w_count_inc;
                            if (w_count_inc <= CW'(2)) begin
                                r_state <= S_RS0;
                            end else if (w_count_inc >= CW'(8)) begin
                                r_state <= S_LEN0;
                            end
                        end
                    end
                end
                S_OVF: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_kind <= rtu_frr_pkg::KIND_OVERFLOW;
                        r_frame_byte <= '0;
                        r_byte_index <= '0;
                        r_last <= 1'b1;
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_RS0: begin
                    r_state <= (r_count == '0) ? S_IDLE : S_RS1;
                end
                S_RS1: begin
                    r_b0 <= w_rdata;
                    if (r_count >= CW'(2)) begin
                        r_state <= S_RS2;
                    end else if (w_rdata != i_station_address) begin
                        r_head <= r_head + PW'(1);
                        r_count <= r_count - 1'b1;
                        r_state <= S_RS0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RS2: begin
                    if ((r_b0 != i_station_address) || !rtu_frr_pkg::code_ok(w_rdata)) begin
                        r_head <= r_head + PW'(1);
                        r_count <= r_count - 1'b1;
                        r_state <= S_RS0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_LEN0: r_state <= S_LEN1;
                S_LEN1: begin
                    if (w_rdata == rtu_frr_pkg::FC_WRITE_MULTI) begin
                        r_state <= S_LEN2;
                    end else if (rtu_frr_pkg::code_ok(w_rdata)) begin
                        r_len <= rtu_frr_pkg::FIXED_LEN;
                        r_state <= S_LENCMP;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_LEN2: begin
                    r_len <= {1'b0, w_rdata} + rtu_frr_pkg::MULTI_HDR;
                    r_state <= S_LENCMP;
                end
                S_LENCMP: begin
                    if (LW'(r_count) < r_len + LW'(2)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_crc <= rtu_frr_pkg::CRC_INIT;
                        r_idx <= '0;
                        r_state <= S_CRC_RD;
                    end
                end
                S_CRC_RD: r_state <= S_CRC_UP;
                S_CRC_UP: begin
                    r_crc <= rtu_frr_pkg::crc_byte(r_crc, w_rdata);
                    r_idx <= r_idx + 1'b1;
                    r_state <= (LW'(r_idx) + LW'(1) == r_len) ? S_CHK0 : S_CRC_RD;
                end
                S_CHK0: r_state <= S_CHK1;
                S_CHK1: begin
                    r_ok <= (w_rdata == r_crc[7:0]);
                    r_state <= S_CHK2;
                end
                S_CHK2: begin
                    r_idx <= '0;
                    r_state <= (r_ok && (w_rdata == r_crc[15:8])) ? S_EMIT_RD : S_ERR;
                end
                S_ERR: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_kind <= rtu_frr_pkg::KIND_CRC_ERR;
                        r_frame_byte <= '0;
                        r_byte_index <= '0;
                        r_last <= 1'b1;
                        r_head <= r_head + PW'(1);
                        r_count <= r_count - 1'b1;
                        r_state <= S_RS0;
                    end
                end
                S_EMIT_RD: r_state <= S_EMIT;
                S_EMIT: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_kind <= rtu_frr_pkg::KIND_FRAME;
                        r_frame_byte <= w_rdata;
                        r_byte_index <= r_idx[5:0];
                        r_last <= (LW'(r_idx) == r_len + LW'(1));
                        if (LW'(r_idx) == r_len + LW'(1)) begin
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind = r_kind;
    assign o_frame_byte = r_frame_byte;
    assign o_byte_index = r_byte_index;
    assign o_last_of_frame = r_last;
endmodule

### hw/rtl/rtu_frame_receiver_resync.sv
// Modbus RTU frame receiver with CRC check and resync on the leading bytes.
// Depends on rtu_frr_pkg, rtu_fe, rtu_be and the assertion macro header.
//
// Received bytes enter a two-item queue and are handled one at a time by a
// sequencer around a 64-byte frame buffer with one read port. Each byte is
// stored in the buffer, then the sequencer resyncs on the leading bytes, looks
// up the frame length, runs the CRC pass over the frame bytes, compares the
// CRC and emits an accepted frame byte by byte while the output is not stalled.
// Each step reads the buffer one byte at a time through its single read port,
// and no new byte leaves the queue until the sequencer is idle again.
`include "rtu_frame_receiver_resync_defines.svh"

module rtu_frame_receiver_resync (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_rx_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_rx_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_frame_byte,
    output logic [5:0] o_byte_index,
    output logic       o_last_of_frame
);
    logic [7:0]            r_station_address;
    rtu_frr_pkg::t_fe_item w_item;
    logic                  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_address <= 8'd1;
        end else if (i_cfg_we) begin
            r_station_address <= i_cfg_wdata;
        end
    end

    rtu_fe u_fe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx_valid(i_rx_valid),
        .i_rx_byte (i_rx_byte),
        .o_rx_stall(o_rx_stall),
        .o_item    (w_item),
        .i_pop     (w_pop)
    );

    rtu_be u_be (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_station_address(r_station_address),
        .i_item           (w_item),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_frame_byte     (o_frame_byte),
        .o_byte_index     (o_byte_index),
        .o_last_of_frame  (o_last_of_frame)
    );

    `RTU_ASSERT_IMP(a_status_clean,
        o_out_valid && (o_kind != rtu_frr_pkg::KIND_FRAME),
        o_last_of_frame && (o_frame_byte == 8'd0) && (o_byte_index == 6'd0),
        "status result carries frame data")
    `RTU_ASSERT_IMP(a_kind_legal, o_out_valid,
        (o_kind == rtu_frr_pkg::KIND_FRAME) || (o_kind == rtu_frr_pkg::KIND_CRC_ERR) ||
        (o_kind == rtu_frr_pkg::KIND_OVERFLOW),
        "illegal result kind")
    `RTU_ASSERT_ALWAYS(a_reset_quiet, $past(!i_rst_n), !o_out_valid && !o_rx_stall,
        "outputs active right after reset")
endmodule
